// ===== design/ssc_pkg.sv =====
// Shared types and constants for the state-space controller step block.
// Used by ssc_ctrl, ssc_datapath and the top level; no dependencies.
package ssc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 32;
	localparam int STATE_BITS = 48;
	localparam int CIDX_W     = 5;
	localparam int OP_W       = 2;
	localparam int MAX_ORDER  = 8;
	localparam int IDX_W      = $clog2(MAX_ORDER + 1);
	// operand split for the two partial products
	localparam int HALF_W     = STATE_BITS / 2;
	localparam int ACC_W      = COEF_W + STATE_BITS + $clog2(MAX_ORDER + 2);

	localparam logic [OP_W-1:0] OP_STEP_ERR = 2'd0;
	localparam logic [OP_W-1:0] OP_STEP_REF = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD     = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

	typedef struct packed {
		logic             start;
		logic             use_ref;
		logic             load;
		logic             clear;
		logic             issue;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             commit;
	} ctl_t;

endpackage

// ===== design/ssc_ctrl.sv =====
// Sequencer for the state-space controller: decodes items, walks the
// multiply-accumulate terms row by row and owns the result handshake.
// Depends on ssc_pkg.
module ssc_ctrl #(
	parameter int STATE_ORDER = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [ssc_pkg::OP_W-1:0]   op,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic                       fin,
	output ssc_pkg::ctl_t              ctl
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [ssc_pkg::IDX_W-1:0] LAST_IDX = ssc_pkg::IDX_W'(STATE_ORDER);

	logic [1:0]                  state_q;
	logic [ssc_pkg::IDX_W-1:0]   row_q;
	logic [ssc_pkg::IDX_W-1:0]   col_q;
	logic                        ovld_q;
	logic                        acc_in;

	assign s_tready = (state_q == ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign m_tvalid = ovld_q;

	always_comb begin
		ctl         = '0;
		ctl.start   = acc_in && (op inside {ssc_pkg::OP_STEP_ERR, ssc_pkg::OP_STEP_REF});
		ctl.use_ref = (op == ssc_pkg::OP_STEP_REF);
		ctl.load    = acc_in && (op == ssc_pkg::OP_LOAD);
		ctl.clear   = acc_in && (op == ssc_pkg::OP_CLEAR);
		ctl.issue   = (state_q == ST_RUN);
		ctl.first   = (col_q == '0);
		ctl.last    = (col_q == LAST_IDX);
		ctl.row     = row_q;
		ctl.col     = col_q;
		ctl.commit  = (state_q == ST_DONE) && (!ovld_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			ovld_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						row_q   <= '0;
						col_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (col_q == LAST_IDX) begin
						col_q <= '0;
						if (row_q == LAST_IDX) begin
							state_q <= ST_DRAIN;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (fin) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ctl.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// hold the result until the transfer completes
			if (ctl.commit) begin
				ovld_q <= 1'b1;
			end else if (m_tready) begin
				ovld_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/ssc_datapath.sv =====
// Datapath of the state-space controller: coefficient store, state vector,
// one pipelined multiply-accumulate unit, rounding, saturation and result
// register. Depends on ssc_pkg; commanded by ssc_ctrl.
module ssc_datapath #(
	parameter int STATE_ORDER    = 4,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ssc_pkg::ctl_t                       ctl,
	input  logic signed [ssc_pkg::SAMPLE_W-1:0] error_in,
	input  logic signed [ssc_pkg::SAMPLE_W-1:0] reference,
	input  logic signed [ssc_pkg::SAMPLE_W-1:0] measurement,
	input  logic [ssc_pkg::CIDX_W-1:0]          coef_index,
	input  logic signed [ssc_pkg::COEF_W-1:0]   coef_value,
	output logic                                fin,
	output logic signed [ssc_pkg::SAMPLE_W-1:0] drive,
	output logic                                saturated
);

	localparam int N          = STATE_ORDER;
	localparam int F          = COEF_FRAC_BITS;
	localparam int SLOT_B     = N * N;
	localparam int SLOT_C     = SLOT_B + N;
	localparam int SLOT_D     = SLOT_C + N;
	localparam int COEF_SLOTS = SLOT_D + 1;
	localparam int AW         = $clog2(COEF_SLOTS);
	localparam int IW         = (AW > ssc_pkg::CIDX_W) ? AW : ssc_pkg::CIDX_W;
	localparam int XW         = (N > 1) ? $clog2(N) : 1;
	localparam int SB         = ssc_pkg::STATE_BITS;
	localparam int CW         = ssc_pkg::COEF_W;
	localparam int SW         = ssc_pkg::SAMPLE_W;
	localparam int HW         = ssc_pkg::HALF_W;
	localparam int AC         = ssc_pkg::ACC_W;
	localparam int IDX_W      = ssc_pkg::IDX_W;
	localparam int PL_W       = CW + HW + 1;
	localparam int PH_W       = CW + SB - HW;

	localparam logic signed [CW-1:0] COEF_ONE = CW'(1) << F;
	localparam logic signed [AC-1:0] HALF_OUT = AC'(1) << (2 * F - 1);
	localparam logic signed [AC-1:0] HALF_ST  = AC'(1) << (F - 1);
	localparam logic signed [SW-1:0] S_MAX    = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN    = {1'b1, {(SW - 1){1'b0}}};
	localparam logic signed [SB-1:0] X_MAX    = {1'b0, {(SB - 1){1'b1}}};
	localparam logic signed [SB-1:0] X_MIN    = {1'b1, {(SB - 1){1'b0}}};
	localparam logic [IDX_W-1:0]     LAST_ROW = IDX_W'(N);

	// coefficient store with per-slot written flags
	logic [CW-1:0]           coef_mem [COEF_SLOTS];
	logic [COEF_SLOTS-1:0]   cvld_q;
	logic [IW-1:0]           widx;
	logic                    widx_ok;
	logic [AW-1:0]           rd_addr;

	logic signed [SB-1:0]    x_q    [N];
	logic signed [SB-1:0]    newx_q [N];
	logic signed [SB-1:0]    fe_q;

	logic signed [SW:0]      diff;
	logic signed [SW-1:0]    err;

	// term pipeline
	logic [CW-1:0]           coef_rd_s1;
	logic                    cvld_s1, dslot_s1;
	logic signed [SB-1:0]    opnd_s1;
	logic                    v_s1, first_s1, last_s1;
	logic [IDX_W-1:0]        row_s1;
	logic signed [CW-1:0]    coef_s1;

	logic signed [PL_W-1:0]  plo_c, plo_s2;
	logic signed [PH_W-1:0]  phi_c, phi_s2;
	logic                    v_s2, first_s2, last_s2;
	logic [IDX_W-1:0]        row_s2;

	logic signed [AC-1:0]    sum_s3;
	logic                    v_s3, first_s3, last_s3;
	logic [IDX_W-1:0]        row_s3;

	logic signed [AC-1:0]    acc_q;
	logic                    done_s4;
	logic [IDX_W-1:0]        row_s4;

	logic signed [AC-1:0]    rnd_s5;
	logic                    v_s5;
	logic [IDX_W-1:0]        row_s5;

	logic signed [AC-1:0]    sh_out, sh_st;
	logic                    fit_out, fit_st, neg_s5;
	logic signed [SW-1:0]    drv_c;
	logic signed [SB-1:0]    newx_c;
	logic                    clip_c;

	logic signed [SW-1:0]    drv_q;
	logic                    clip_q;
	logic signed [SW-1:0]    out_drive_q;
	logic                    out_sat_q;

	assign drive     = out_drive_q;
	assign saturated = out_sat_q;

	// error sample: error_in, or for a reference step the difference clipped to the sample range
	always_comb begin
		diff = (SW + 1)'(reference) - (SW + 1)'(measurement);
		if (diff[SW] != diff[SW-1]) begin
			err = diff[SW] ? S_MIN : S_MAX;
		end else begin
			err = diff[SW-1:0];
		end
		if (!ctl.use_ref) begin
			err = error_in;
		end
	end

	assign widx    = IW'(coef_index);
	assign widx_ok = (widx < IW'(COEF_SLOTS));

	// slot of the term: row 0 is the output row, row r the update of x[r-1]
	always_comb begin
		if (ctl.row == '0) begin
			rd_addr = (ctl.col == '0) ? AW'(SLOT_D) : AW'(SLOT_C) + AW'(ctl.col) - AW'(1);
		end else if (ctl.col == '0) begin
			rd_addr = AW'(SLOT_B) + AW'(ctl.row) - AW'(1);
		end else begin
			rd_addr = AW'(ctl.row - IDX_W'(1)) * AW'(N) + AW'(ctl.col) - AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && widx_ok) begin
			coef_mem[widx[AW-1:0]] <= coef_value;
		end
	end

	always_ff @(posedge clk) begin
		coef_rd_s1 <= coef_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q <= '0;
		end else if (ctl.load && widx_ok) begin
			cvld_q[widx[AW-1:0]] <= 1'b1;
		end
	end

	// stage 1: coefficient read and operand select
	always_ff @(posedge clk) begin
		cvld_s1  <= cvld_q[rd_addr];
		dslot_s1 <= (rd_addr == AW'(SLOT_D));
		opnd_s1  <= (ctl.col == '0) ? fe_q : x_q[XW'(ctl.col - IDX_W'(1))];
		first_s1 <= ctl.first;
		last_s1  <= ctl.last;
		row_s1   <= ctl.row;
	end

	// unwritten slots read as their reset value
	assign coef_s1 = cvld_s1 ? $signed(coef_rd_s1) : (dslot_s1 ? COEF_ONE : '0);

	// stage 2: two partial products, low half unsigned
	always_comb begin
		plo_c = PL_W'(coef_s1) * PL_W'($signed({1'b0, opnd_s1[HW-1:0]}));
		phi_c = PH_W'(coef_s1) * PH_W'($signed(opnd_s1[SB-1:HW]));
	end

	always_ff @(posedge clk) begin
		plo_s2   <= plo_c;
		phi_s2   <= phi_c;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
	end

	// stage 3: recombine
	always_ff @(posedge clk) begin
		sum_s3   <= (AC'(phi_s2) <<< HW) + AC'(plo_s2);
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		row_s3   <= row_s2;
	end

	// stage 4: accumulate, restart on the first term of a row
	always_ff @(posedge clk) begin
		if (v_s3) begin
			acc_q <= first_s3 ? sum_s3 : acc_q + sum_s3;
		end
		row_s4 <= row_s3;
	end

	// stage 5: add half an LSB of the target format
	always_ff @(posedge clk) begin
		rnd_s5 <= acc_q + ((row_s4 == '0) ? HALF_OUT : HALF_ST);
		row_s5 <= row_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			done_s4 <= 1'b0;
			v_s5    <= 1'b0;
		end else begin
			v_s1    <= ctl.issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			done_s4 <= v_s3 && last_s3;
			v_s5    <= done_s4;
		end
	end

	// stage 6: shift down and saturate
	always_comb begin
		sh_out  = rnd_s5 >>> (2 * F);
		sh_st   = rnd_s5 >>> F;
		neg_s5  = rnd_s5[AC-1];
		fit_out = (&sh_out[AC-1:SW-1]) || !(|sh_out[AC-1:SW-1]);
		fit_st  = (&sh_st[AC-1:SB-1]) || !(|sh_st[AC-1:SB-1]);
		drv_c   = fit_out ? sh_out[SW-1:0] : (neg_s5 ? S_MIN : S_MAX);
		newx_c  = fit_st ? sh_st[SB-1:0] : (neg_s5 ? X_MIN : X_MAX);
		clip_c  = (row_s5 == '0) ? !fit_out : !fit_st;
	end

	assign fin = v_s5 && (row_s5 == LAST_ROW);

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			fe_q <= SB'(err) <<< F;
		end
		if (v_s5) begin
			if (row_s5 == '0) begin
				drv_q <= drv_c;
			end else begin
				newx_q[XW'(row_s5 - IDX_W'(1))] <= newx_c;
			end
		end
		if (ctl.commit) begin
			out_drive_q <= drv_q;
			out_sat_q   <= clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
		end else if (ctl.start) begin
			clip_q <= 1'b0;
		end else if (v_s5 && clip_c) begin
			clip_q <= 1'b1;
		end
	end

	// state vector: zeroed by a clear item; every new element comes from the old vector, so swap at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				x_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			for (int i = 0; i < N; i++) begin
				x_q[i] <= '0;
			end
		end else if (ctl.commit) begin
			for (int i = 0; i < N; i++) begin
				x_q[i] <= newx_q[i];
			end
		end
	end

endmodule

// ===== design/state_space_controller_step_top.sv =====
// Step item: one term a cycle into the shared multiply-accumulate unit, then multiply,
// recombine, accumulate, round, saturate and output stages. The next item is taken only
// once the step's result is committed; a held result stalls the next step's finish.
// Load and clear give no result. Reset: state zero, coefficients zero but D = one.
// Depends on ssc_pkg, ssc_ctrl and ssc_datapath.
module state_space_controller_step_top #(
	parameter int STATE_ORDER    = 4,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// error_in[15:0], reference[31:16], measurement[47:32], coef_index[52:48],
	// coef_value[84:53], zero fill[87:85]
	input  logic [87:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// drive[15:0]
	output logic [15:0] m_tdata,
	// saturated[0]
	output logic [0:0]  m_tuser
);

	ssc_pkg::ctl_t                       ctl;
	logic                                fin;
	logic signed [ssc_pkg::SAMPLE_W-1:0] drive;
	logic                                saturated;

	ssc_ctrl #(
		.STATE_ORDER (STATE_ORDER)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.fin      (fin),
		.ctl      (ctl)
	);

	ssc_datapath #(
		.STATE_ORDER    (STATE_ORDER),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.error_in    ($signed(s_tdata[15:0])),
		.reference   ($signed(s_tdata[31:16])),
		.measurement ($signed(s_tdata[47:32])),
		.coef_index  (s_tdata[52:48]),
		.coef_value  ($signed(s_tdata[84:53])),
		.fin         (fin),
		.drive       (drive),
		.saturated   (saturated)
	);

	assign m_tdata    = drive;
	assign m_tuser[0] = saturated;

endmodule
